@@ rtl/mtlu_pkg.sv @@
// Shared constants, types and SHA-256 helpers for the Merkle leaf update/check block.
// No dependencies.
package mtlu_pkg;

  localparam int LEAF_COUNT_MAX = 256;
  localparam int LOG2_MAX       = $clog2(LEAF_COUNT_MAX);
  localparam int NODE_DEPTH     = 2 * LEAF_COUNT_MAX - 1;
  localparam int NODE_W         = $clog2(NODE_DEPTH);
  localparam int LVL_W          = 4;
  localparam int DIGEST_W       = 256;

  localparam logic [1:0] OP_CHECK  = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_INIT   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic start;
    logic first;
  } sha_ctl_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Padding block for a 64-byte message.
  localparam logic [511:0] SHA_PAD64 = {32'h80000000, 416'd0, 32'd0, 32'd512};

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    rotr32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/mtlu_in_if.sv @@
// Input channel: valid/ready handshake with operation, index and leaf digest.
// Uses no package.
interface mtlu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  block_index;
  logic [63:0] leaf_hash_0;
  logic [63:0] leaf_hash_1;
  logic [63:0] leaf_hash_2;
  logic [63:0] leaf_hash_3;

  modport source (output valid, operation, block_index, leaf_hash_0, leaf_hash_1,
                  leaf_hash_2, leaf_hash_3, input ready);
  modport sink (input valid, operation, block_index, leaf_hash_0, leaf_hash_1,
                leaf_hash_2, leaf_hash_3, output ready);
endinterface

@@ rtl/mtlu_out_if.sv @@
// Result channel: valid/ready handshake with status and root digest.
// Uses no package.
interface mtlu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] root_word_0;
  logic [63:0] root_word_1;
  logic [63:0] root_word_2;
  logic [63:0] root_word_3;

  modport source (output valid, status, root_word_0, root_word_1, root_word_2,
                  root_word_3, input ready);
  modport sink (input valid, status, root_word_0, root_word_1, root_word_2,
                root_word_3, output ready);
endinterface

@@ rtl/mtlu_sha_core.sv @@
// Iterative SHA-256 compression core, one round per cycle, then a final add step.
// Depends on mtlu_pkg.
module mtlu_sha_core import mtlu_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  sha_ctl_t       ctl,
  input  logic [511:0]   block,
  output logic           done,
  output logic [255:0]   digest
);

  logic [31:0] hv_r  [8];
  logic [31:0] v_r   [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r   [16];
  logic [31:0] w_nxt [16];
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        add_r;
  logic        done_r;

  logic [31:0] t1, t2, big_s0, big_s1, ch, maj, sm0, sm1;
  logic [255:0] base;

  assign base = ctl.first ? SHA_IV : {hv_r[0], hv_r[1], hv_r[2], hv_r[3],
                                      hv_r[4], hv_r[5], hv_r[6], hv_r[7]};

  always_comb begin
    big_s1 = rotr32(v_r[4], 6) ^ rotr32(v_r[4], 11) ^ rotr32(v_r[4], 25);
    ch     = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1     = v_r[7] + big_s1 + ch + SHA_K[cnt_r] + w_r[0];
    big_s0 = rotr32(v_r[0], 2) ^ rotr32(v_r[0], 13) ^ rotr32(v_r[0], 22);
    maj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2     = big_s0 + maj;
    v_nxt[0] = t1 + t2;
    v_nxt[1] = v_r[0];
    v_nxt[2] = v_r[1];
    v_nxt[3] = v_r[2];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[5] = v_r[4];
    v_nxt[6] = v_r[5];
    v_nxt[7] = v_r[6];
    sm0 = rotr32(w_r[1], 7) ^ rotr32(w_r[1], 18) ^ (w_r[1] >> 3);
    sm1 = rotr32(w_r[14], 17) ^ rotr32(w_r[14], 19) ^ (w_r[14] >> 10);
    for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i + 1];
    w_nxt[15] = w_r[0] + sm0 + w_r[9] + sm1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      add_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r && !add_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          add_r  <= 1'b1;
        end
      end else if (add_r) begin
        add_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r && !add_r) begin
      for (int i = 0; i < 8; i++) begin
        hv_r[i] <= base[255 - 32 * i -: 32];
        v_r[i]  <= base[255 - 32 * i -: 32];
      end
      for (int i = 0; i < 16; i++) w_r[i] <= block[511 - 32 * i -: 32];
    end else if (busy_r) begin
      v_r <= v_nxt;
      w_r <= w_nxt;
    end else if (add_r) begin
      for (int i = 0; i < 8; i++) hv_r[i] <= hv_r[i] + v_r[i];
    end
  end

  assign done   = done_r;
  assign digest = {hv_r[0], hv_r[1], hv_r[2], hv_r[3], hv_r[4], hv_r[5], hv_r[6], hv_r[7]};

endmodule

@@ rtl/merkle_tree_leaf_update_check.sv @@
// Merkle tree of SHA-256 digests kept as a heap in a node memory; top level.
// Depends on mtlu_pkg, mtlu_in_if, mtlu_out_if and mtlu_sha_core.
//
//  channel | direction | transfer moves
//  in_ch   | in        | operation, block_index, leaf_hash_0..3
//  out_ch  | out       | status, root_word_0..3
//  cfg_*   | in        | leaf_count_log2 (write only)
//
// One item at a time. Every hash takes two compressions on the shared core.
// Update writes the leaf, then for each of the L levels of the tree fetches both
// children and hashes them. Initialize: one node write per cycle for all
// 2^(L+1)-1 nodes, held during the L node hashes between levels. Check compares
// the leaf; a rejected index or the unused code only reads the root. Reset clears
// control only; the node memory holds nothing until the first initialize. A
// stalled result holds in the output register and blocks the next input transfer.
module merkle_tree_leaf_update_check import mtlu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  mtlu_in_if.sink     in_ch,
  mtlu_out_if.source  out_ch
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CRD    = 4'd1;
  localparam logic [3:0] S_CCMP   = 4'd2;
  localparam logic [3:0] S_UPAR   = 4'd3;
  localparam logic [3:0] S_URDR   = 4'd4;
  localparam logic [3:0] S_UWL    = 4'd5;
  localparam logic [3:0] S_UST    = 4'd6;
  localparam logic [3:0] S_UH1    = 4'd7;
  localparam logic [3:0] S_UH2    = 4'd8;
  localparam logic [3:0] S_IFILL  = 4'd9;
  localparam logic [3:0] S_IST    = 4'd10;
  localparam logic [3:0] S_IH1    = 4'd11;
  localparam logic [3:0] S_IH2    = 4'd12;
  localparam logic [3:0] S_RROOT  = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0]          state_r, state_nxt;
  logic [3:0]          cfg_l2_r;
  logic [1:0]          status_r, status_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [NODE_W-1:0]   fill_r, fill_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [DIGEST_W-1:0] hash_r, hash_nxt;
  logic [DIGEST_W-1:0] left_r, left_nxt;

  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [DIGEST_W-1:0] out_root_r;

  logic [DIGEST_W-1:0] tree_mem [NODE_DEPTH];
  logic [DIGEST_W-1:0] rd_data_r;
  logic                mem_we;
  logic [NODE_W-1:0]   mem_wa, mem_ra;
  logic [DIGEST_W-1:0] mem_wd;

  sha_ctl_t            sha_ctl;
  logic [511:0]        sha_block;
  logic                sha_done;
  logic [DIGEST_W-1:0] sha_digest;

  logic                in_xfer;
  logic [LVL_W-1:0]    eff_l2;
  logic [NODE_W:0]     leaf_n;
  logic [NODE_W:0]     lvl_end, lvl_first;
  logic [NODE_W-1:0]   parent;

  // Clamp the leaf count register into the supported range.
  always_comb begin
    priority if (cfg_l2_r < 4'd1) eff_l2 = 4'd1;
    else if (cfg_l2_r > LVL_W'(LOG2_MAX)) eff_l2 = LVL_W'(LOG2_MAX);
    else eff_l2 = cfg_l2_r;
  end

  assign leaf_n    = (NODE_W + 1)'(1) << eff_l2;
  assign lvl_end   = ((NODE_W + 1)'(1) << (lvl_r + 4'd1)) - (NODE_W + 1)'(2);
  assign lvl_first = ((NODE_W + 1)'(1) << (lvl_r - 4'd1)) - (NODE_W + 1)'(1);
  assign parent    = (node_r - NODE_W'(1)) >> 1;

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    node_nxt   = node_r;
    fill_nxt   = fill_r;
    lvl_nxt    = lvl_r;
    hash_nxt   = hash_r;
    left_nxt   = left_r;
    mem_we     = 1'b0;
    mem_wa     = node_r;
    mem_wd     = hash_r;
    mem_ra     = '0;
    sha_ctl    = '{start: 1'b0, first: 1'b1};
    sha_block  = {left_r, rd_data_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          status_nxt = ST_OK;
          hash_nxt   = {in_ch.leaf_hash_0, in_ch.leaf_hash_1,
                        in_ch.leaf_hash_2, in_ch.leaf_hash_3};
          node_nxt   = NODE_W'(leaf_n - (NODE_W + 1)'(1)) + NODE_W'(in_ch.block_index);
          fill_nxt   = NODE_W'(leaf_n - (NODE_W + 1)'(1));
          lvl_nxt    = eff_l2;
          priority if (in_ch.operation == OP_INIT) begin
            state_nxt = S_IFILL;
          end else if (in_ch.operation != OP_CHECK && in_ch.operation != OP_UPDATE) begin
            state_nxt = S_RROOT;
          end else if ({1'b0, in_ch.block_index} >= leaf_n) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_RROOT;
          end else if (in_ch.operation == OP_CHECK) begin
            state_nxt = S_CRD;
          end else begin
            // Write the leaf now, then walk up.
            mem_we    = 1'b1;
            mem_wa    = node_nxt;
            mem_wd    = hash_nxt;
            state_nxt = S_UPAR;
          end
        end
      end
      S_CRD: begin
        mem_ra    = node_r;
        state_nxt = S_CCMP;
      end
      S_CCMP: begin
        if (rd_data_r != hash_r) status_nxt = ST_MISMATCH;
        state_nxt = S_RROOT;
      end
      S_UPAR: begin
        if (node_r == '0) begin
          state_nxt = S_RROOT;
        end else begin
          node_nxt  = parent;
          mem_ra    = NODE_W'({parent, 1'b1});
          state_nxt = S_URDR;
        end
      end
      S_URDR: begin
        // Left child arrives now; start the right child read.
        left_nxt  = rd_data_r;
        mem_ra    = NODE_W'({node_r, 1'b0}) + NODE_W'(2);
        state_nxt = S_UWL;
      end
      S_UWL: begin
        // Hold the right child address so its data is in place at the start.
        mem_ra    = NODE_W'({node_r, 1'b0}) + NODE_W'(2);
        state_nxt = S_UST;
      end
      S_UST: begin
        sha_ctl   = '{start: 1'b1, first: 1'b1};
        state_nxt = S_UH1;
      end
      S_UH1: begin
        if (sha_done) begin
          sha_ctl   = '{start: 1'b1, first: 1'b0};
          sha_block = SHA_PAD64;
          state_nxt = S_UH2;
        end
      end
      S_UH2: begin
        if (sha_done) begin
          mem_we    = 1'b1;
          mem_wa    = node_r;
          mem_wd    = sha_digest;
          state_nxt = S_UPAR;
        end
      end
      S_IFILL: begin
        // Every node on one level holds the same digest after initialize.
        mem_we = 1'b1;
        mem_wa = fill_r;
        mem_wd = hash_r;
        fill_nxt = fill_r + NODE_W'(1);
        if ({1'b0, fill_r} == lvl_end) begin
          if (lvl_r == '0) begin
            state_nxt = S_RROOT;
          end else begin
            fill_nxt  = NODE_W'(lvl_first);
            lvl_nxt   = lvl_r - LVL_W'(1);
            state_nxt = S_IST;
          end
        end
      end
      S_IST: begin
        sha_ctl   = '{start: 1'b1, first: 1'b1};
        sha_block = {hash_r, hash_r};
        state_nxt = S_IH1;
      end
      S_IH1: begin
        if (sha_done) begin
          sha_ctl   = '{start: 1'b1, first: 1'b0};
          sha_block = SHA_PAD64;
          state_nxt = S_IH2;
        end
      end
      S_IH2: begin
        if (sha_done) begin
          hash_nxt  = sha_digest;
          state_nxt = S_IFILL;
        end
      end
      S_RROOT: begin
        mem_ra    = '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_l2_r    <= 4'd8;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cfg_l2_r <= cfg_wdata;
      // Load the result; hold it until the sink takes it.
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    node_r   <= node_nxt;
    fill_r   <= fill_nxt;
    lvl_r    <= lvl_nxt;
    hash_r   <= hash_nxt;
    left_r   <= left_nxt;
    if (state_r == S_OUT) begin
      out_status_r <= status_r;
      out_root_r   <= rd_data_r;
    end
  end

  // Node memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) tree_mem[mem_wa] <= mem_wd;
    rd_data_r <= tree_mem[mem_ra];
  end

  mtlu_sha_core u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sha_ctl),
    .block  (sha_block),
    .done   (sha_done),
    .digest (sha_digest)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.root_word_0 = out_root_r[255:192];
  assign out_ch.root_word_1 = out_root_r[191:128];
  assign out_ch.root_word_2 = out_root_r[127:64];
  assign out_ch.root_word_3 = out_root_r[63:0];

endmodule

@@ rtl/mtlu_checker.sv @@
// Port-level checks on the Merkle leaf update/check block, bound to its top level.
// Depends on merkle_tree_leaf_update_check and mtlu_pkg.
module mtlu_checker import mtlu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_no_in_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result waits");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_MISMATCH ||
                   out_status == ST_RANGE))
    else $error("undefined status code");

endmodule

bind merkle_tree_leaf_update_check mtlu_checker u_mtlu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status)
);

@@ bench/tb_merkle_tree_leaf_update_check.sv @@
// Self-checking bench for merkle_tree_leaf_update_check: directed table, then random phases.
// Depends on mtlu_pkg, mtlu_in_if, mtlu_out_if and the block itself.
`timescale 1ns / 1ps
module tb_merkle_tree_leaf_update_check;
  import mtlu_pkg::*;

  localparam int TREE_NODES = 2 * LEAF_COUNT_MAX - 1;
  localparam int IDLE_LIMIT = 40000;  // no-transfer cycles before giving up

  typedef struct packed {
    logic [1:0]   status;
    logic [255:0] root;
  } root_report_t;

  typedef struct {
    logic         do_cfg;
    logic [3:0]   cfg;
    logic [1:0]   op;
    logic [7:0]   idx;
    logic [255:0] digest;
    logic         typed;   // status written in the row, not predicted
    logic [1:0]   status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;

  mtlu_in_if  in_ch ();
  mtlu_out_if out_ch ();

  merkle_tree_leaf_update_check dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the tree and the leaf-count register.
  logic [255:0] node_digest [TREE_NODES];
  logic [3:0]   leaf_log2_reg = 4'd8;
  root_report_t pending_roots [$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;  // no idling on either side while set

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_block(logic [255:0] st, logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = st;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {st[255:224] + a, st[223:192] + b, st[191:160] + c, st[159:128] + d,
            st[127:96] + e, st[95:64] + f, st[63:32] + g, st[31:0] + h};
  endfunction

  function automatic logic [255:0] pair_digest(logic [255:0] l, logic [255:0] r);
    return sha_block(sha_block(SHA_IV, {l, r}), SHA_PAD64);
  endfunction

  function automatic int used_log2();
    if (leaf_log2_reg < 1) return 1;
    if (leaf_log2_reg > LOG2_MAX) return LOG2_MAX;
    return leaf_log2_reg;
  endfunction

  // Apply one operation to the shadow tree and return status plus new root.
  function automatic root_report_t apply_op(logic [1:0] op, logic [7:0] idx,
                                            logic [255:0] digest);
    int lg, n, node;
    logic [255:0] lvl;
    root_report_t r;
    lg = used_log2();
    n = 1 << lg;
    r.status = ST_OK;
    if (op == OP_INIT) begin
      // Every leaf is equal, so every node of a level holds the same digest.
      lvl = digest;
      for (int i = 0; i < n; i++) node_digest[n - 1 + i] = digest;
      for (int k = lg - 1; k >= 0; k--) begin
        lvl = pair_digest(lvl, lvl);
        for (int i = (1 << k) - 1; i < (1 << (k + 1)) - 1; i++) node_digest[i] = lvl;
      end
    end else if (op == OP_CHECK || op == OP_UPDATE) begin
      if (idx >= n) r.status = ST_RANGE;
      else begin
        node = n - 1 + idx;
        if (op == OP_CHECK) begin
          if (node_digest[node] != digest) r.status = ST_MISMATCH;
        end else begin
          node_digest[node] = digest;
          while (node > 0) begin
            node = (node - 1) / 2;
            node_digest[node] = pair_digest(node_digest[2*node + 1], node_digest[2*node + 2]);
          end
        end
      end
    end
    r.root = node_digest[0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // Present one item, hold it until the transfer, then predict it.
  task automatic send_item(logic [1:0] op, logic [7:0] idx, logic [255:0] digest,
                           logic typed, logic [1:0] status);
    root_report_t r;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.block_index <= idx;
    {in_ch.leaf_hash_0, in_ch.leaf_hash_1, in_ch.leaf_hash_2, in_ch.leaf_hash_3} <= digest;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_op(op, idx, digest);
    if (typed) r.status = status;
    pending_roots.push_back(r);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain outstanding results, then write the register while the block is idle.
  task automatic write_leaf_log2(logic [3:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    leaf_log2_reg = v;
  endtask

  function automatic logic [255:0] rand_digest();
    logic [255:0] d;
    for (int j = 0; j < 4; j++) begin
      case ($urandom_range(0, 9))
        0: d[255 - 64*j -: 64] = '0;
        1: d[255 - 64*j -: 64] = '1;
        default: d[255 - 64*j -: 64] = {$urandom(), $urandom()};
      endcase
    end
    return d;
  endfunction

  // Result side: random back-pressure and in-order comparison.
  int out_stall = 0;
  always @(posedge clk) begin
    root_report_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_roots.size() == 0) begin
          $error("unexpected result transfer, status %0d", out_ch.status);
          errors++;
        end else begin
          want = pending_roots.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            errors++;
          end
          if (out_ch.root_word_0 !== want.root[255:192]) begin
            $error("root_word_0: expected %h, got %h", want.root[255:192], out_ch.root_word_0);
            errors++;
          end
          if (out_ch.root_word_1 !== want.root[191:128]) begin
            $error("root_word_1: expected %h, got %h", want.root[191:128], out_ch.root_word_1);
            errors++;
          end
          if (out_ch.root_word_2 !== want.root[127:64]) begin
            $error("root_word_2: expected %h, got %h", want.root[127:64], out_ch.root_word_2);
            errors++;
          end
          if (out_ch.root_word_3 !== want.root[63:0]) begin
            $error("root_word_3: expected %h, got %h", want.root[63:0], out_ch.root_word_3);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  localparam logic [255:0] D_ZERO = '0;
  localparam logic [255:0] D_ONES = '1;
  localparam logic [255:0] D_A5   = {32{8'hA5}};
  localparam logic [255:0] D_SEQ  = {8{32'h01234567}} ^ {4{64'h89abcdef_fedcba98}};

  // Directed rows: extremes of the fields, every operation, range and clamp cases.
  stim_row_t directed [] = '{
    '{0, 4'd0, OP_INIT,   8'd0,   D_ZERO, 0, ST_OK},
    '{0, 4'd0, OP_CHECK,  8'd0,   D_ZERO, 1, ST_OK},
    '{0, 4'd0, OP_CHECK,  8'd255, D_ONES, 1, ST_MISMATCH},
    '{0, 4'd0, OP_UPDATE, 8'd0,   D_ONES, 1, ST_OK},
    '{0, 4'd0, OP_UPDATE, 8'd255, D_SEQ,  1, ST_OK},
    '{0, 4'd0, OP_CHECK,  8'd255, D_SEQ,  1, ST_OK},
    '{0, 4'd0, 2'd3,      8'd77,  D_A5,   1, ST_OK},
    '{0, 4'd0, OP_INIT,   8'd255, D_ONES, 0, ST_OK},
    '{0, 4'd0, OP_CHECK,  8'd128, D_ONES, 1, ST_OK},
    '{0, 4'd0, OP_UPDATE, 8'd127, D_A5,   0, ST_OK},
    '{1, 4'd1, OP_INIT,   8'd0,   D_A5,   0, ST_OK},
    '{0, 4'd0, OP_CHECK,  8'd2,   D_A5,   1, ST_RANGE},
    '{0, 4'd0, OP_UPDATE, 8'd255, D_ZERO, 1, ST_RANGE},
    '{0, 4'd0, OP_UPDATE, 8'd1,   D_ZERO, 0, ST_OK},
    '{0, 4'd0, OP_CHECK,  8'd1,   D_ZERO, 1, ST_OK},
    '{0, 4'd0, OP_CHECK,  8'd0,   D_ZERO, 1, ST_MISMATCH},
    '{1, 4'd0, OP_INIT,   8'd0,   D_SEQ,  0, ST_OK},
    '{0, 4'd0, OP_CHECK,  8'd2,   D_SEQ,  1, ST_RANGE},
    '{0, 4'd0, OP_UPDATE, 8'd0,   D_ONES, 0, ST_OK},
    '{1, 4'd15, OP_INIT,  8'd0,   D_ZERO, 0, ST_OK},
    '{0, 4'd0, OP_UPDATE, 8'd200, D_A5,   0, ST_OK},
    '{0, 4'd0, OP_CHECK,  8'd200, D_A5,   1, ST_OK}
  };

  int phase_log2 [] = '{1, 3, 0, 5, 9, 2, 8, 4, 6, 15, 7};

  initial begin
    int n, idx, r;
    logic [1:0] op;
    logic [255:0] d;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_CHECK;
    in_ch.block_index = '0;
    {in_ch.leaf_hash_0, in_ch.leaf_hash_1, in_ch.leaf_hash_2, in_ch.leaf_hash_3} = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; reset value of the register is exercised first.
    foreach (directed[i]) begin
      if (directed[i].do_cfg) write_leaf_log2(directed[i].cfg);
      send_item(directed[i].op, directed[i].idx, directed[i].digest,
                directed[i].typed, directed[i].status);
    end

    // Random phases: every phase opens with an initialize, then mostly valid
    // updates and checks against known leaves, with some noise mixed in.
    foreach (phase_log2[p]) begin
      write_leaf_log2(phase_log2[p][3:0]);
      quiet = (p % 4 == 3);
      n = 1 << used_log2();
      send_item(OP_INIT, $urandom_range(0, 255), rand_digest(), 1'b0, ST_OK);
      for (int k = 0; k < 37; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) op = OP_UPDATE;
        else if (r < 88) op = OP_CHECK;
        else if (r < 94) op = OP_INIT;
        else op = 2'd3;
        idx = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
        d = rand_digest();
        if (op == OP_CHECK && idx < n) begin
          r = $urandom_range(0, 9);
          if (r < 6) d = node_digest[n - 1 + idx];
          else if (r < 8) d = node_digest[n - 1 + idx] ^ (256'd1 << $urandom_range(0, 255));
        end
        send_item(op, idx[7:0], d, 1'b0, ST_OK);
      end
    end

    // Drain, then allow the block some settling time.
    in_ch.valid <= 1'b0;
    quiet = 1'b0;
    @(posedge clk);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (pending_roots.size() != 0) errors++;
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mtlu_pkg.sv
rtl/mtlu_in_if.sv
rtl/mtlu_out_if.sv
rtl/mtlu_sha_core.sv
rtl/merkle_tree_leaf_update_check.sv
rtl/mtlu_checker.sv
bench/tb_merkle_tree_leaf_update_check.sv
